// File: sv/nmeachk_pkg.sv
// ----------------------------------------------------------------------------
// NMEA sentence checker package
// Shared constants, verdict codes and result type.
// ----------------------------------------------------------------------------
package nmeachk_pkg;

  localparam int unsigned MaxRawLengthDef = 256;

  localparam int unsigned DataW   = 8;
  localparam int unsigned ResultW = 24;

  localparam logic [7:0] CharDollar = 8'h24;
  localparam logic [7:0] CharStar   = 8'h2a;
  localparam logic [7:0] CharCr     = 8'h0d;
  localparam logic [7:0] CharLf     = 8'h0a;
  localparam logic [7:0] PrintLo    = 8'h20;
  localparam logic [7:0] PrintHi    = 8'h7e;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_FORMAT   = 2'd1,
    STATUS_LENGTH   = 2'd2,
    STATUS_CHECKSUM = 2'd3
  } status_e;

  typedef struct packed {
    logic [7:0] packet_length;
    logic [7:0] computed_checksum;
    status_e    status;
  } result_t;

endpackage

// File: sv/nmeachk_core.sv
// ----------------------------------------------------------------------------
// NMEA sentence checker core
// Per-sentence parse state and verdict logic, one byte per cycle when item_valid_i is high.
// ----------------------------------------------------------------------------
module nmeachk_core #(
  parameter int unsigned MAX_RAW_LENGTH = nmeachk_pkg::MaxRawLengthDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 item_valid_i,
  input  logic [7:0]           data_byte_i,
  input  logic                 last_byte_i,
  output logic                 res_valid_o,
  output nmeachk_pkg::result_t res_o
);
  import nmeachk_pkg::*;

  localparam int unsigned CntW = $clog2(MAX_RAW_LENGTH + 1);
  localparam int unsigned SumW = CntW + 2;
  localparam logic [SumW-1:0] MaxLen = SumW'(MAX_RAW_LENGTH);

  typedef enum logic {
    PHASE_DOLLAR,
    PHASE_COLLECT
  } phase_e;

  typedef struct packed {
    phase_e     phase;
    logic       fault;
    logic [7:0] xorv;
    logic [1:0] fill;
    logic [7:0] win0;
    logic [7:0] win1;
    logic [7:0] win2;
  } parse_t;

  localparam parse_t ParseClear = '{
    phase: PHASE_DOLLAR, fault: 1'b0, xorv: 8'h00, fill: 2'd0,
    win0: 8'h00, win1: 8'h00, win2: 8'h00
  };

  function automatic parse_t push_byte(parse_t s, logic [7:0] b);
    parse_t r;
    r = s;
    if (s.phase == PHASE_DOLLAR) begin
      if (b != CharDollar) r.fault = 1'b1;
      r.phase = PHASE_COLLECT;
    end else if (s.fill == 2'd3) begin
      if (s.win0 < PrintLo || s.win0 > PrintHi || s.win0 == CharDollar ||
          s.win0 == CharStar) r.fault = 1'b1;
      r.xorv = s.xorv ^ s.win0;
      r.win0 = s.win1;
      r.win1 = s.win2;
      r.win2 = b;
    end else begin
      case (s.fill)
        2'd0:    r.win0 = b;
        2'd1:    r.win1 = b;
        default: r.win2 = b;
      endcase
      r.fill = s.fill + 2'd1;
    end
    return r;
  endfunction

  function automatic logic [7:0] hex_char(logic [3:0] nib);
    return (nib < 4'd10) ? (8'h30 + {4'h0, nib}) : (8'h37 + {4'h0, nib});
  endfunction

  function automatic logic [7:0] to_upper(logic [7:0] c);
    return (c inside {[8'h61:8'h7a]}) ? (c - 8'h20) : c;
  endfunction

  logic [CntW-1:0] raw_q, raw_d;
  logic [CntW-1:0] trim_q, trim_d;
  logic [CntW-1:0] pend_q, pend_d;
  parse_t          parse_q, parse_d;

  logic [SumW-1:0] raw_sum, trim_sum, pend_sum;
  logic [CntW-1:0] raw_new, trim_new, pend_new;
  parse_t          parse_new;
  logic [2:0]      n_cr;
  logic            is_break;
  result_t         res;

  always_comb begin
    is_break = (data_byte_i == CharCr) || (data_byte_i == CharLf);
    raw_sum  = SumW'(raw_q) + SumW'(1);
    raw_new  = (raw_sum > MaxLen) ? CntW'(MAX_RAW_LENGTH) : raw_sum[CntW-1:0];
    pend_sum = SumW'(pend_q) + SumW'(1);
    trim_sum = SumW'(trim_q) + SumW'(pend_q) + SumW'(1);
    n_cr     = (pend_q > CntW'(4)) ? 3'd4 : pend_q[2:0];
    trim_new  = trim_q;
    pend_new  = pend_q;
    parse_new = parse_q;
    if (is_break) begin
      pend_new = (pend_sum > MaxLen) ? CntW'(MAX_RAW_LENGTH) : pend_sum[CntW-1:0];
    end else begin
      for (int i = 0; i < 4; i++) begin
        if (3'(i) < n_cr) parse_new = push_byte(parse_new, CharCr);
      end
      parse_new = push_byte(parse_new, data_byte_i);
      trim_new  = (trim_sum > MaxLen) ? CntW'(MAX_RAW_LENGTH) : trim_sum[CntW-1:0];
      pend_new  = '0;
    end

    res.computed_checksum = 8'h00;
    res.packet_length     = 8'h00;
    if (SumW'(raw_new) >= MaxLen || SumW'(trim_new) + SumW'(3) > MaxLen) begin
      res.status = STATUS_LENGTH;
    end else if (trim_new < CntW'(5) || parse_new.fault || parse_new.win0 != CharStar) begin
      res.status = STATUS_FORMAT;
    end else begin
      res.computed_checksum = parse_new.xorv;
      if (to_upper(parse_new.win1) != hex_char(parse_new.xorv[7:4]) ||
          to_upper(parse_new.win2) != hex_char(parse_new.xorv[3:0])) begin
        res.status = STATUS_CHECKSUM;
      end else begin
        res.status        = STATUS_OK;
        res.packet_length = 8'(SumW'(trim_new) + SumW'(2));
      end
    end

    if (last_byte_i) begin
      raw_d   = '0;
      trim_d  = '0;
      pend_d  = '0;
      parse_d = ParseClear;
    end else begin
      raw_d   = raw_new;
      trim_d  = trim_new;
      pend_d  = pend_new;
      parse_d = parse_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      raw_q   <= '0;
      trim_q  <= '0;
      pend_q  <= '0;
      parse_q <= ParseClear;
    end else if (item_valid_i) begin
      raw_q   <= raw_d;
      trim_q  <= trim_d;
      pend_q  <= pend_d;
      parse_q <= parse_d;
    end
  end

  assign res_valid_o = item_valid_i && last_byte_i;
  assign res_o       = res;

endmodule

// File: sv/nmea_sentence_checker.sv
// ----------------------------------------------------------------------------
// NMEA sentence checker
// Checks size, form and checksum of byte-streamed sentences, one verdict each.
// ----------------------------------------------------------------------------
// Slave stream: one sentence byte per transaction in tdata, tlast on the
// final byte. Master stream: one verdict transaction per sentence, issued
// for the transaction that carries tlast; no output for other bytes.
// Trailing CR/LF bytes stay out of the parse and the normalized length but
// count toward the raw length limit; status is ok, format, length or
// checksum, with the computed XOR and the normalized length beside it.
// Throughput is one byte per cycle unless the receiver stalls: the input
// register feeds a combinational parse update whose verdict lands in the
// output register. Reset clears the valid flags of both registers and the
// parse state; the next byte starts a new sentence. When the receiver holds
// tready low, the verdict waits in the output register, one more byte waits
// in the input register, so s_axis_tready drops until the verdict is taken.
// ----------------------------------------------------------------------------
module nmea_sentence_checker #(
  parameter int unsigned MAX_RAW_LENGTH = nmeachk_pkg::MaxRawLengthDef
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [nmeachk_pkg::DataW-1:0]       s_axis_tdata,  // [7:0] data_byte
  input  logic                                s_axis_tlast,  // last_byte
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // [1:0] status, [9:2] computed_checksum, [17:10] packet_length, [23:18] zero
  output logic [nmeachk_pkg::ResultW-1:0]     m_axis_tdata
);
  import nmeachk_pkg::*;

  logic       in_valid_q;
  logic [7:0] in_data_q;
  logic       in_last_q;
  logic       out_valid_q;
  result_t    out_res_q;
  logic       advance;
  logic       item_valid;
  logic       res_valid;
  result_t    res;

  assign advance       = !out_valid_q || m_axis_tready;
  assign s_axis_tready = !in_valid_q || advance;
  assign item_valid    = in_valid_q && advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tvalid && s_axis_tready) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_data_q <= s_axis_tdata;
      in_last_q <= s_axis_tlast;
    end
  end

  nmeachk_core #(
    .MAX_RAW_LENGTH(MAX_RAW_LENGTH)
  ) u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (item_valid),
    .data_byte_i  (in_data_q),
    .last_byte_i  (in_last_q),
    .res_valid_o  (res_valid),
    .res_o        (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && res_valid) begin
      out_res_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {6'b0, out_res_q.packet_length,
                          out_res_q.computed_checksum, out_res_q.status};

`ifndef ASSERT_OFF
  a_no_cks_on_reject: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (out_res_q.status == STATUS_FORMAT ||
                    out_res_q.status == STATUS_LENGTH)
    |-> out_res_q.computed_checksum == 8'h00)
    else $error("checksum reported for rejected sentence");

  a_len_only_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_res_q.status != STATUS_OK
    |-> out_res_q.packet_length == 8'h00)
    else $error("length reported for failed sentence");

  a_hold_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !advance |=> in_valid_q && $stable(in_data_q) && $stable(in_last_q))
    else $error("input register lost a stalled byte");
`endif

endmodule

// File: tb/tb_nmea_sentence_checker.sv
// ----------------------------------------------------------------------------
// NMEA sentence checker testbench
// Streams directed and random sentences into the checker, with bursty input
// and a stalling receiver. Every verdict is checked against an in-bench
// sentence predictor.
// ----------------------------------------------------------------------------
module tb_nmea_sentence_checker;
  import nmeachk_pkg::*;

  localparam int unsigned MaxLen       = MaxRawLengthDef;
  localparam int unsigned ByteTarget   = 1750;
  localparam int unsigned IdleLimit    = 4000;
  localparam int unsigned DrainCycles  = 20;
  localparam int unsigned HoldAfter    = 600;
  localparam int unsigned HoldCycles   = 400;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } sentence_byte_t;

  typedef struct packed {
    status_e    status;
    logic [7:0] checksum;
    logic [7:0] length;
  } verdict_t;

  logic              clk_i         = 1'b0;
  logic              rst_ni        = 1'b0;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [DataW-1:0]  s_axis_tdata  = '0;  // [7:0] data_byte
  logic              s_axis_tlast  = 1'b0;  // last_byte
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  // [1:0] status, [9:2] computed_checksum, [17:10] packet_length, [23:18] zero
  logic [ResultW-1:0] m_axis_tdata;

  nmea_sentence_checker dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  sentence_byte_t byte_q[$];
  logic [7:0]     frame_q[$];
  verdict_t       verdict_q[$];

  int unsigned fail_count;
  int unsigned mismatch_count;
  int unsigned accepted_bytes;
  int unsigned verdict_count;
  int unsigned status_seen[4];

  // predictor state
  int unsigned sn_raw;
  int unsigned sn_trimmed;
  int unsigned sn_breaks;
  logic [7:0]  sn_xor;
  logic        sn_collecting;
  logic        sn_fault;
  logic [7:0]  sn_win[3];
  int unsigned sn_fill;

  function automatic int unsigned sat_len(int unsigned v);
    return (v > MaxLen) ? MaxLen : v;
  endfunction

  function automatic logic [7:0] hex_char(logic [3:0] n);
    return (n < 4'd10) ? (8'h30 + 8'(n)) : (8'h41 + 8'(n) - 8'd10);
  endfunction

  function automatic logic [7:0] to_upper(logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7a) ? (c - 8'h20) : c;
  endfunction

  task clear_sentence();
    sn_raw        = 0;
    sn_trimmed    = 0;
    sn_breaks     = 0;
    sn_xor        = '0;
    sn_collecting = 1'b0;
    sn_fault      = 1'b0;
    sn_win[0]     = '0;
    sn_win[1]     = '0;
    sn_win[2]     = '0;
    sn_fill       = 0;
  endtask

  task push_trimmed(input logic [7:0] b);
    logic [7:0] e;
    if (!sn_collecting) begin
      if (b != CharDollar) sn_fault = 1'b1;
      sn_collecting = 1'b1;
    end else if (sn_fill >= 3) begin
      e = sn_win[0];
      if (e < PrintLo || e > PrintHi || e == CharDollar || e == CharStar) sn_fault = 1'b1;
      sn_xor    = sn_xor ^ e;
      sn_win[0] = sn_win[1];
      sn_win[1] = sn_win[2];
      sn_win[2] = b;
    end else begin
      sn_win[sn_fill] = b;
      sn_fill++;
    end
  endtask

  task absorb_byte(input logic [7:0] b, input logic last);
    int unsigned n;
    verdict_t    v;
    sn_raw = sat_len(sn_raw + 1);
    if (b == CharCr || b == CharLf) begin
      sn_breaks = sat_len(sn_breaks + 1);
    end else begin
      n = (sn_breaks > 4) ? 4 : sn_breaks;
      for (int i = 0; i < n; i++) push_trimmed(CharCr);
      push_trimmed(b);
      sn_trimmed = sat_len(sn_trimmed + sn_breaks + 1);
      sn_breaks  = 0;
    end
    if (last) begin
      v.checksum = '0;
      v.length   = '0;
      if (sn_raw >= MaxLen || sn_trimmed + 3 > MaxLen) begin
        v.status = STATUS_LENGTH;
      end else if (sn_trimmed < 5 || sn_fault || sn_win[0] != CharStar) begin
        v.status = STATUS_FORMAT;
      end else begin
        v.checksum = sn_xor;
        if (to_upper(sn_win[1]) != hex_char(sn_xor[7:4]) ||
            to_upper(sn_win[2]) != hex_char(sn_xor[3:0])) begin
          v.status = STATUS_CHECKSUM;
        end else begin
          v.status = STATUS_OK;
          v.length = 8'(sn_trimmed + 2);
        end
      end
      verdict_q.push_back(v);
      clear_sentence();
    end
  endtask

  // stimulus helpers
  task put_char(input logic [7:0] b);
    frame_q.push_back(b);
  endtask

  task put_text(input string s);
    for (int i = 0; i < s.len(); i++) frame_q.push_back(s.getc(i));
  endtask

  task flush_frame();
    sentence_byte_t item;
    for (int i = 0; i < frame_q.size(); i++) begin
      item.data = frame_q[i];
      item.last = (i == frame_q.size() - 1);
      byte_q.push_back(item);
    end
    frame_q.delete();
  endtask

  function automatic logic [7:0] body_char();
    logic [7:0] c;
    do c = 8'($urandom_range(32'h20, 32'h7e));
    while (c == CharDollar || c == CharStar);
    return c;
  endfunction

  function automatic logic [7:0] break_char();
    return $urandom_range(0, 1) ? CharCr : CharLf;
  endfunction

  function automatic logic [7:0] digit_char(logic [3:0] n);
    logic [7:0] c;
    c = hex_char(n);
    if (c >= 8'h41 && $urandom_range(0, 1)) c = c + 8'h20;
    return c;
  endfunction

  task add_random_sentence(input int unsigned idx);
    int unsigned kind;
    int unsigned body_len;
    int unsigned trail;
    int unsigned pos;
    int unsigned run;
    logic [7:0]  x;
    logic [7:0]  c;
    kind     = $urandom_range(0, 99);
    body_len = (idx % 25 == 24) ? $urandom_range(240, 262) : $urandom_range(0, 16);
    trail    = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 2) : $urandom_range(3, 8);
    if (kind >= 85) begin
      run = $urandom_range(1, 12);
      for (int i = 0; i < run; i++) begin
        if ($urandom_range(0, 5) == 0) put_char(break_char());
        else put_char(8'($urandom));
      end
    end else begin
      x = '0;
      put_char(CharDollar);
      for (int i = 0; i < body_len; i++) begin
        c = body_char();
        x = x ^ c;
        put_char(c);
      end
      put_char(CharStar);
      put_char(digit_char(x[7:4]));
      put_char(digit_char(x[3:0]));
      if (kind >= 55) begin
        pos = $urandom_range(0, frame_q.size() - 1);
        case ($urandom_range(0, 4))
          0: frame_q[pos] = 8'($urandom);
          1: begin
            run = $urandom_range(1, 6);
            for (int i = 0; i < run; i++) frame_q.insert(pos, break_char());
          end
          2: frame_q[pos] = frame_q[pos] ^ (8'h01 << $urandom_range(0, 7));
          3: frame_q.delete(pos);
          default: frame_q[frame_q.size() - 1] = digit_char(4'(x[3:0] + 4'd1));
        endcase
      end
    end
    for (int i = 0; i < trail; i++) put_char(break_char());
    flush_frame();
  endtask

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    int unsigned idx;
    clear_sentence();
    fail_count     = 0;
    mismatch_count = 0;
    verdict_count  = 0;
    for (int i = 0; i < 4; i++) status_seen[i] = 0;

    put_text("$A*41"); put_char(CharCr); put_char(CharLf); flush_frame();
    put_char(8'h00); flush_frame();
    put_text("$J*4a"); flush_frame();
    put_text("$A*40"); flush_frame();
    put_char(8'hff); flush_frame();
    put_text("$A"); put_char(CharCr); put_text("*41"); flush_frame();
    put_char(CharCr); put_char(CharLf); flush_frame();

    idx = 0;
    while (byte_q.size() < ByteTarget) begin
      add_random_sentence(idx);
      idx++;
    end

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (byte_q.size() != 0 || verdict_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (verdict_q.size() != 0) fail_count++;

    $display("Streamed %0d bytes, checked %0d verdicts with %0d mismatches", accepted_bytes,
             verdict_count, mismatch_count);
    $display("Verdicts: %0d ok, %0d format, %0d length, %0d checksum", status_seen[0],
             status_seen[1], status_seen[2], status_seen[3]);
    if (fail_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // driver
  int unsigned burst_left;
  int unsigned gap_left;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid  <= 1'b0;
      s_axis_tdata   <= '0;
      s_axis_tlast   <= 1'b0;
      accepted_bytes <= 0;
      burst_left = 0;
      gap_left   = 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        absorb_byte(byte_q[0].data, byte_q[0].last);
        byte_q.pop_front();
        accepted_bytes <= accepted_bytes + 1;
      end
      if (!(s_axis_tvalid && !s_axis_tready)) begin
        if (gap_left > 0) begin
          gap_left--;
          s_axis_tvalid <= 1'b0;
        end else if (byte_q.size() > 0) begin
          if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 200)
                                                     : $urandom_range(1, 20);
          end
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= byte_q[0].data;
          s_axis_tlast  <= byte_q[0].last;
          burst_left--;
          if (burst_left == 0) gap_left = $urandom_range(0, 8);
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver stall pattern, with one long hold-off
  int unsigned pat_left;
  logic        pat_ready;
  int unsigned hold_left;
  logic        hold_done;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      pat_left  = 0;
      pat_ready = 1'b1;
      hold_left = 0;
      hold_done = 1'b0;
    end else begin
      if (!hold_done && accepted_bytes >= HoldAfter) begin
        hold_left = HoldCycles;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        if (pat_left == 0) begin
          if ($urandom_range(0, 9) < 4) begin
            pat_ready = 1'b1;
            pat_left  = $urandom_range(20, 120);
          end else begin
            pat_ready = $urandom_range(0, 1);
            pat_left  = $urandom_range(1, 6);
          end
        end
        pat_left--;
        m_axis_tready <= pat_ready;
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    verdict_t exp_v;
    status_e  act_status;
    logic [7:0] act_cks;
    logic [7:0] act_len;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      act_status = status_e'(m_axis_tdata[1:0]);
      act_cks    = m_axis_tdata[9:2];
      act_len    = m_axis_tdata[17:10];
      if (verdict_q.size() == 0) begin
        fail_count++;
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("Unexpected verdict: status %0d checksum %02h length %0d", act_status,
                   act_cks, act_len);
      end else begin
        exp_v = verdict_q.pop_front();
        verdict_count++;
        status_seen[exp_v.status]++;
        if (act_status != exp_v.status || act_cks != exp_v.checksum ||
            act_len != exp_v.length) begin
          fail_count++;
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("Verdict %0d mismatch: expected status %0d checksum %02h length %0d",
                     verdict_count, exp_v.status, exp_v.checksum, exp_v.length);
            $display("  got status %0d checksum %02h length %0d", act_status, act_cks,
                     act_len);
          end
        end
      end
    end
  end

  // watchdog
  int unsigned idle_cycles;

  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("Watchdog expired after %0d idle cycles", idle_cycles);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule
